>>> rtl/core/sva_pkg.sv
package sva_pkg;

	localparam int SLOTS_DEF = 8;

	localparam int ENT_W  = 16;
	localparam int CH_W   = 4;
	localparam int SND_W  = 10;
	localparam int LEN_W  = 24;
	localparam int NOW_W  = 31;
	localparam int END_W  = 32;
	localparam int SLOT_W = 3;

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_STOP  = 1'b1;

	localparam logic [CH_W-1:0]  CH_ANY     = 4'hF;
	localparam logic [CH_W-1:0]  CH_NONE    = 4'h0;
	localparam logic [SND_W-1:0] SND_NONE   = '0;
	localparam logic [END_W-1:0] LIFE_INIT  = 32'h7FFF_FFFF;
	localparam logic [ENT_W-1:0] PLAYER_RST = 16'd1;

	// controller -> datapath
	typedef struct packed {
		logic start;     // request transaction taken
		logic rd;        // issue slot read, advance scan index
		logic eval;      // read data of previous issue is valid
		logic write;     // commit chosen slot
		logic load_out;  // load result register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic nosnd;     // incoming start carries no sound
		logic rd_last;   // scan index points at last slot
		logic hit;       // evaluated slot ends the scan
	} sts_t;

endpackage

>>> rtl/core/sva_if.sv
interface sva_req_if;
	logic                        valid;
	logic                        ready;
	logic                        req_type;
	logic [sva_pkg::ENT_W-1:0]   entity;
	logic signed [sva_pkg::CH_W-1:0] ent_channel;
	logic [sva_pkg::SND_W-1:0]   sound_id;
	logic [sva_pkg::LEN_W-1:0]   sound_length;
	logic [sva_pkg::NOW_W-1:0]   now;

	modport source (output valid, req_type, entity, ent_channel, sound_id, sound_length, now,
		input ready);
	modport sink (input valid, req_type, entity, ent_channel, sound_id, sound_length, now,
		output ready);
endinterface

interface sva_rsp_if;
	logic                        valid;
	logic                        ready;
	logic                        granted;
	logic [sva_pkg::SLOT_W-1:0]  slot;
	logic                        same_source;
	logic                        evicted_active;

	modport source (output valid, granted, slot, same_source, evicted_active, input ready);
	modport sink (input valid, granted, slot, same_source, evicted_active, output ready);
endinterface

interface sva_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [sva_pkg::ENT_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/sva_ctrl.sv
module sva_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	input  sva_pkg::sts_t sts,
	output sva_pkg::cmd_t cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_WRITE = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0] state_q;
	logic       rd_on_q;
	logic       eval_q;
	logic       last_q;
	logic       rsp_vld_q;
	logic       acc;
	logic       scan_end;
	logic       out_free;

	assign req_ready = (state_q == ST_IDLE);
	assign acc       = req_valid && req_ready;
	assign out_free  = !rsp_vld_q || rsp_ready;
	assign rsp_valid = rsp_vld_q;

	always_comb begin
		cmd          = '0;
		cmd.start    = acc;
		cmd.rd       = (state_q == ST_SCAN) && rd_on_q;
		cmd.eval     = (state_q == ST_SCAN) && eval_q;
		cmd.write    = (state_q == ST_WRITE);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	assign scan_end = cmd.eval && (sts.hit || last_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			rd_on_q   <= 1'b0;
			eval_q    <= 1'b0;
			last_q    <= 1'b0;
			rsp_vld_q <= 1'b0;
		end else begin
			eval_q <= cmd.rd;
			last_q <= cmd.rd && sts.rd_last;
			if (cmd.load_out) begin
				rsp_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						if (sts.nosnd) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_SCAN;
							rd_on_q <= 1'b1;
						end
					end
				end
				ST_SCAN: begin
					if (scan_end) begin
						state_q <= ST_WRITE;
					end
					// stop issuing reads after the last slot or on an early hit
					if (scan_end || (cmd.rd && sts.rd_last)) begin
						rd_on_q <= 1'b0;
					end
				end
				ST_WRITE: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> rtl/core/sva_dp.sv
module sva_dp #(
	parameter int SLOTS = sva_pkg::SLOTS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sva_pkg::cmd_t              cmd,
	output sva_pkg::sts_t              sts,
	input  logic                       cfg_wr,
	input  logic [sva_pkg::ENT_W-1:0]  cfg_data,
	input  logic                       in_req_type,
	input  logic [sva_pkg::ENT_W-1:0]  in_entity,
	input  logic [sva_pkg::CH_W-1:0]   in_channel,
	input  logic [sva_pkg::SND_W-1:0]  in_sound,
	input  logic [sva_pkg::LEN_W-1:0]  in_length,
	input  logic [sva_pkg::NOW_W-1:0]  in_now,
	output logic                       out_granted,
	output logic [sva_pkg::SLOT_W-1:0] out_slot,
	output logic                       out_same,
	output logic                       out_active
);

	localparam int IW = $clog2(SLOTS);

	localparam int ENT_W = sva_pkg::ENT_W;
	localparam int CH_W  = sva_pkg::CH_W;
	localparam int SND_W = sva_pkg::SND_W;
	localparam int LEN_W = sva_pkg::LEN_W;
	localparam int NOW_W = sva_pkg::NOW_W;
	localparam int END_W = sva_pkg::END_W;

	// slot table
	logic [ENT_W-1:0] mem_ent [SLOTS];
	logic [CH_W-1:0]  mem_ch  [SLOTS];
	logic [SND_W-1:0] mem_snd [SLOTS];
	logic [END_W-1:0] mem_end [SLOTS];
	logic [SLOTS-1:0] valid_q;

	logic [ENT_W-1:0] player_q;

	// latched request
	logic             stop_q;
	logic [ENT_W-1:0] ent_q;
	logic [CH_W-1:0]  ch_q;
	logic [SND_W-1:0] snd_q;
	logic [LEN_W-1:0] len_q;
	logic [NOW_W-1:0] now_q;

	// scan
	logic [IW-1:0]    cnt_q;
	logic [IW-1:0]    idx_s1;
	logic             val_s1;
	logic [ENT_W-1:0] ent_s1;
	logic [CH_W-1:0]  ch_s1;
	logic [SND_W-1:0] snd_s1;
	logic [END_W-1:0] end_s1;

	logic [END_W-1:0] best_q;
	logic [IW-1:0]    pick_q;
	logic             found_q;
	logic             same_q;
	logic             act_q;

	logic [ENT_W-1:0] e_ent;
	logic [CH_W-1:0]  e_ch;
	logic [SND_W-1:0] e_snd;
	logic [END_W-1:0] e_end;
	logic [END_W-1:0] life;
	logic             same_hit;
	logic             stop_hit;
	logic             prot;
	logic             better;
	logic             hit;
	logic [IW+2:0]    pick_ext;

	// unwritten entries read as zero
	assign e_ent = val_s1 ? ent_s1 : '0;
	assign e_ch  = val_s1 ? ch_s1  : '0;
	assign e_snd = val_s1 ? snd_s1 : '0;
	assign e_end = val_s1 ? end_s1 : '0;

	assign same_hit = (ch_q != sva_pkg::CH_NONE) && (e_ent == ent_q)
		&& ((e_ch == ch_q) || (ch_q == sva_pkg::CH_ANY));
	assign stop_hit = (e_ent == ent_q) && (e_ch == ch_q);
	assign prot     = (e_ent == player_q) && (ent_q != player_q) && (e_snd != sva_pkg::SND_NONE);
	assign life     = e_end - END_W'(now_q);
	assign better   = $signed(life) < $signed(best_q);
	assign hit      = (stop_q == sva_pkg::REQ_STOP) ? stop_hit : same_hit;

	assign sts.nosnd   = (in_req_type == sva_pkg::REQ_START) && (in_sound == sva_pkg::SND_NONE);
	assign sts.rd_last = (cnt_q == IW'(SLOTS - 1));
	assign sts.hit     = hit;

	assign pick_ext = {3'b000, pick_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			player_q <= sva_pkg::PLAYER_RST;
			valid_q  <= '0;
		end else begin
			if (cfg_wr) begin
				player_q <= cfg_data;
			end
			if (cmd.write && found_q && (stop_q == sva_pkg::REQ_START)) begin
				valid_q[pick_q] <= 1'b1;
			end
		end
	end

	// table write and registered read
	always_ff @(posedge clk) begin
		if (cmd.write && found_q) begin
			if (stop_q == sva_pkg::REQ_START) begin
				mem_ent[pick_q] <= ent_q;
				mem_ch[pick_q]  <= ch_q;
				mem_snd[pick_q] <= snd_q;
				mem_end[pick_q] <= END_W'(now_q) + END_W'(len_q);
			end else if (valid_q[pick_q]) begin
				mem_snd[pick_q] <= '0;
				mem_end[pick_q] <= '0;
			end
		end
		if (cmd.rd) begin
			ent_s1 <= mem_ent[cnt_q];
			ch_s1  <= mem_ch[cnt_q];
			snd_s1 <= mem_snd[cnt_q];
			end_s1 <= mem_end[cnt_q];
			val_s1 <= valid_q[cnt_q];
			idx_s1 <= cnt_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			stop_q  <= in_req_type;
			ent_q   <= in_entity;
			ch_q    <= in_channel;
			snd_q   <= in_sound;
			len_q   <= in_length;
			now_q   <= in_now;
			cnt_q   <= '0;
			best_q  <= sva_pkg::LIFE_INIT;
			pick_q  <= '0;
			found_q <= 1'b0;
			same_q  <= 1'b0;
			act_q   <= 1'b0;
		end else begin
			if (cmd.rd) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.eval) begin
				if (hit) begin
					pick_q  <= idx_s1;
					found_q <= 1'b1;
					same_q  <= (stop_q == sva_pkg::REQ_START);
					act_q   <= (e_snd != sva_pkg::SND_NONE);
				end else if ((stop_q == sva_pkg::REQ_START) && !prot && better) begin
					best_q  <= life;
					pick_q  <= idx_s1;
					found_q <= 1'b1;
					act_q   <= (e_snd != sva_pkg::SND_NONE);
				end
			end
		end
		if (cmd.load_out) begin
			out_granted <= found_q;
			out_slot    <= found_q ? pick_ext[2:0] : '0;
			out_same    <= found_q && same_q;
			out_active  <= found_q && act_q;
		end
	end

endmodule

>>> rtl/core/sound_voice_allocator_unit.sv
// Channel  Role    Transaction carries
// -------  ------  ---------------------------------------------------------
// cfg      sink    data: player_entity (16b), always ready
// req      sink    req_type, entity, ent_channel, sound_id, sound_length, now
// rsp      source  granted, slot, same_source, evicted_active
//
// One request at a time. After acceptance the slot table is read one entry
// per cycle through its registered read port, and each entry is evaluated
// as its read data returns; a commit state then writes the chosen slot and
// the final state loads the result register. The next request is taken once
// the final state is left. A start without a sound skips scan and commit and
// goes straight to the final state. An override or stop match ends the scan
// early. The result register lets the next request be taken while rsp
// stalls; a second result waits in the final state until the first is taken.
// Reset clears per-slot valid bits at once; no sweep.
module sound_voice_allocator_unit #(
	parameter int SLOTS = sva_pkg::SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sva_cfg_if.sink   cfg,
	sva_req_if.sink   req,
	sva_rsp_if.source rsp
);

	sva_pkg::cmd_t cmd;
	sva_pkg::sts_t sts;

	// register writes are always taken
	assign cfg.ready = 1'b1;

	// sequencer: accept, scan, commit, result hand-off
	sva_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// slot table, compare logic and result register
	sva_dp #(
		.SLOTS (SLOTS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg_wr      (cfg.valid),
		.cfg_data    (cfg.data),
		.in_req_type (req.req_type),
		.in_entity   (req.entity),
		.in_channel  (req.ent_channel),
		.in_sound    (req.sound_id),
		.in_length   (req.sound_length),
		.in_now      (req.now),
		.out_granted (rsp.granted),
		.out_slot    (rsp.slot),
		.out_same    (rsp.same_source),
		.out_active  (rsp.evicted_active)
	);

endmodule
